// ===== hdl/crc32_signature_classifier_unit_macros.svh =====
// ---------------------------------------------------------------------------
// CRC-32 signature classifier: assertion macros
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef CRC32_SIGNATURE_CLASSIFIER_UNIT_MACROS_SVH
`define CRC32_SIGNATURE_CLASSIFIER_UNIT_MACROS_SVH
`ifndef SYNTH
`define CSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSC_ASSERT(lbl, clk, rst, prop)
`define CSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/csc_pkg.sv =====
// ---------------------------------------------------------------------------
// csc_pkg
// Types and codes shared by the classifier modules, and the CRC-32 byte step.
// ---------------------------------------------------------------------------
package csc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [2:0] CLS_OTHER   = 3'd0;
  localparam logic [2:0] CLS_DEPTH   = 3'd1;
  localparam logic [2:0] CLS_MOON    = 3'd2;
  localparam logic [2:0] CLS_GRADE   = 3'd3;
  localparam logic [2:0] CLS_FOLIAGE = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    REQ_LOAD,
    REQ_LOOKUP,
    REQ_FAIL
  } req_op_t;

  typedef struct packed {
    req_op_t     op;
    logic [31:0] sig;
    logic        vertex;
    logic [7:0]  idx;
    logic [2:0]  cls;
    logic [7:0]  val;
  } req_t;

  typedef struct packed {
    logic [31:0] sig;
    logic [2:0]  cls;
    logic [7:0]  val;
  } entry_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_DRAIN
  } back_state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc32_signature_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// crc32_signature_classifier_unit
// CRC-32 of a byte-streamed blob, classified against a loaded signature table.
// ---------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Blob bytes,
// loads and fetch failures are each taken by the front, which keeps the
// running CRC and places in-range loads, lookups and failures in a four-deep
// request queue. The back applies a load as it pops it, reports a failure in
// the cycle after it pops it, and answers a lookup after a full sweep of the
// table RAM through its single read port. Once the table is cleared, busy
// rises only when the queue is full, so bytes stream at one per cycle while a
// sweep runs until the queue fills, and any request that arrives while four
// requests wait is held off. Each result shows on the result ports with done
// high for exactly one cycle; the receiver cannot stall it. After reset the
// table is cleared one entry per cycle with busy held high.
// ---------------------------------------------------------------------------
module crc32_signature_classifier_unit #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        pass_type,
  input  logic [7:0]  entry_index,
  input  logic [31:0] entry_signature,
  input  logic [2:0]  entry_class,
  input  logic [7:0]  entry_value,
  output logic        done,
  output logic [2:0]  shader_class,
  output logic [7:0]  grade_value,
  output logic [31:0] signature
);
  import csc_pkg::*;

  req_t push_req;
  req_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic clearing;

  csc_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .kind            (kind),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .pass_type       (pass_type),
    .entry_index     (entry_index),
    .entry_signature (entry_signature),
    .entry_class     (entry_class),
    .entry_value     (entry_value),
    .q_full          (q_full),
    .clearing        (clearing),
    .busy            (busy),
    .push            (push),
    .push_req        (push_req)
  );

  csc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  csc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .shader_class (shader_class),
    .grade_value  (grade_value),
    .signature    (signature)
  );

endmodule

// ===== hdl/csc_ram.sv =====
// ---------------------------------------------------------------------------
// csc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module csc_ram #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/csc_front.sv =====
// ---------------------------------------------------------------------------
// csc_front
// Accepts items, runs the CRC-32 over blob bytes and queues requests.
// ---------------------------------------------------------------------------
module csc_front #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    kind,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          pass_type,
  input  logic [7:0]    entry_index,
  input  logic [31:0]   entry_signature,
  input  logic [2:0]    entry_class,
  input  logic [7:0]    entry_value,
  input  logic          q_full,
  input  logic          clearing,
  output logic          busy,
  output logic          push,
  output csc_pkg::req_t push_req
);
  import csc_pkg::*;

  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [31:0] crc_step;
  logic        accept;
  logic        in_range;

  assign busy     = clearing | q_full;
  assign accept   = start & ~busy;
  assign crc_step = crc_byte(crc, data_byte);
  assign in_range = 32'(entry_index) < 32'(TABLE_ENTRIES);

  always_comb begin
    crc_next     = crc;
    push         = 1'b0;
    push_req.op  = REQ_LOAD;
    push_req.sig = entry_signature;
    push_req.vertex = pass_type;
    push_req.idx = entry_index;
    push_req.cls = entry_class;
    push_req.val = entry_value;
    if (accept) begin
      case (kind)
        KIND_LOAD: begin
          push = in_range;
        end
        KIND_BYTE: begin
          crc_next = crc_step;
          if (last_byte) begin
            push         = 1'b1;
            push_req.op  = REQ_LOOKUP;
            push_req.sig = ~crc_step;
            crc_next     = CRC_ONES;
          end
        end
        KIND_FAIL: begin
          push        = 1'b1;
          push_req.op = REQ_FAIL;
          crc_next    = CRC_ONES;
        end
        default: begin
          crc_next = crc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_ONES;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

// ===== hdl/csc_queue.sv =====
// ---------------------------------------------------------------------------
// csc_queue
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module csc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csc_pkg::req_t push_req,
  input  logic          pop,
  output csc_pkg::req_t head,
  output logic          empty,
  output logic          full
);
  import csc_pkg::*;

  req_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign empty = count == '0;
  assign full  = count == (QAW+1)'(QDEPTH);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// ===== hdl/csc_back.sv =====
// ---------------------------------------------------------------------------
// csc_back
// Clears the table, applies loads, reports failures and sweeps the table for each lookup.
// ---------------------------------------------------------------------------
`include "crc32_signature_classifier_unit_macros.svh"

module csc_back #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  csc_pkg::req_t head,
  input  logic          empty,
  output logic          pop,
  output logic          clearing,
  output logic          done,
  output logic [2:0]    shader_class,
  output logic [7:0]    grade_value,
  output logic [31:0]   signature
);
  import csc_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int EW = $bits(entry_t);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  back_state_t state;
  back_state_t state_next;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_next;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wentry;
  logic          re;
  logic [EW-1:0] rdata;
  entry_t        rentry;
  logic          rd_valid;
  logic          start_scan;
  logic          emit_fail;
  logic          emit_scan;

  logic [31:0] sig_q;
  logic        vertex_q;
  logic        hit_hi;
  logic        hit_mg;
  logic [2:0]  mg_cls;
  logic [7:0]  mg_val;
  logic        match;
  logic        hit_hi_next;
  logic        mg_take;
  logic [2:0]  fin_cls;
  logic [7:0]  fin_val;

  csc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  assign rentry   = entry_t'(rdata);
  assign clearing = state == B_CLEAR;
  assign match    = rd_valid && (rentry.sig == sig_q);
  assign hit_hi_next = hit_hi | (match && (vertex_q ? (rentry.cls == CLS_FOLIAGE)
                                                    : (rentry.cls == CLS_DEPTH)));
  assign mg_take  = match && !vertex_q && !hit_mg &&
                    ((rentry.cls == CLS_MOON) || (rentry.cls == CLS_GRADE));

  always_comb begin
    fin_cls = CLS_OTHER;
    fin_val = 8'd0;
    if (hit_hi_next) begin
      fin_cls = vertex_q ? CLS_FOLIAGE : CLS_DEPTH;
    end else if (hit_mg) begin
      fin_cls = mg_cls;
      fin_val = mg_val;
    end else if (mg_take) begin
      fin_cls = rentry.cls;
      fin_val = rentry.val;
    end
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    we         = 1'b0;
    waddr      = addr;
    wentry     = '0;
    re         = 1'b0;
    pop        = 1'b0;
    start_scan = 1'b0;
    emit_fail  = 1'b0;
    emit_scan  = 1'b0;
    case (state)
      B_CLEAR: begin
        we        = 1'b1;
        addr_next = addr + 1'b1;
        if (addr == LAST) begin
          addr_next  = '0;
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.op)
            REQ_LOAD: begin
              we         = 1'b1;
              waddr      = AW'(head.idx);
              wentry.sig = head.sig;
              wentry.cls = head.cls;
              wentry.val = head.val;
            end
            REQ_LOOKUP: begin
              start_scan = 1'b1;
              addr_next  = '0;
              state_next = B_SCAN;
            end
            REQ_FAIL: begin
              emit_fail = 1'b1;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_SCAN: begin
        re        = 1'b1;
        addr_next = addr + 1'b1;
        if (addr == LAST) begin
          addr_next  = '0;
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        emit_scan  = 1'b1;
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      addr     <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      addr     <= addr_next;
      rd_valid <= re;
      done     <= emit_fail | emit_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      sig_q    <= head.sig;
      vertex_q <= head.vertex;
      hit_hi   <= 1'b0;
      hit_mg   <= 1'b0;
    end else begin
      hit_hi <= hit_hi_next;
      if (mg_take) begin
        hit_mg <= 1'b1;
        mg_cls <= rentry.cls;
        mg_val <= rentry.val;
      end
    end
    if (emit_fail) begin
      shader_class <= CLS_OTHER;
      grade_value  <= 8'd0;
      signature    <= 32'd0;
    end else if (emit_scan) begin
      shader_class <= fin_cls;
      grade_value  <= fin_val;
      signature    <= sig_q;
    end
  end

  `CSC_ASSERT(a_clear_no_pop, clk, rst, (state == B_CLEAR) |-> !pop)
  `CSC_ASSERT(a_grade_class, clk, rst, (done && grade_value != 8'd0) |-> (shader_class == CLS_MOON || shader_class == CLS_GRADE))
  `CSC_ASSERT(a_rd_from_scan, clk, rst, rd_valid |-> $past(state == B_SCAN))
  `CSC_ASSERT(a_no_result_in_scan, clk, rst, (state == B_SCAN || state == B_DRAIN) |-> !done)
  `CSC_ASSERT_NEXT(a_scan_enters, clk, rst, start_scan, state == B_SCAN && addr == '0)

endmodule
